/* rtl/pfd_pkg.sv */
// Shared constants for the PD follow-drive controller.
package pfd_pkg;

    // Command characters that run a control step.
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_C = 8'h43;

    // Field widths that the interface fixes.
    localparam int GAIN_W     = 16;
    localparam int SP_W       = 8;
    localparam int DUTY_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_SP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_SP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_SP     = 3'd4;

    // Setpoint indexes.
    localparam logic [1:0] IDX_NEAR = 2'd0;
    localparam logic [1:0] IDX_MID  = 2'd1;
    localparam logic [1:0] IDX_FAR  = 2'd2;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1966;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd13107;
    localparam logic [SP_W-1:0]   NEAR_SP_RST    = 8'd63;
    localparam logic [SP_W-1:0]   MID_SP_RST     = 8'd123;
    localparam logic [SP_W-1:0]   FAR_SP_RST     = 8'd183;

    // Control law constants, Q16 where fractional.
    localparam int unsigned DEADBAND_Q16 = 52428;
    localparam int unsigned FWD_BASE     = 10000;
    localparam int unsigned REV_BASE     = 11000;
    localparam int unsigned DUTY_SLOPE   = 700;
    localparam int unsigned DUTY_MAX     = 30000;
    localparam int unsigned DERIV_DIV    = 10;

    // Duty arithmetic: the output magnitude is clamped to 31 bits before the
    // slope multiply, which already saturates either duty.
    localparam int MAG_CLAMP_W = 31;
    localparam int SCALE_SH    = 16;
    localparam int SCALED_W    = 25;
    localparam int DUTY_SUM_W  = 26;

endpackage

/* rtl/pfd_mul.sv */
// Shared signed multiplier with a registered product.
module pfd_mul #(
    parameter int A_W = 17,
    parameter int B_W = 32
) (
    input  logic                     aclk,
    input  logic signed [A_W-1:0]    op_a,
    input  logic signed [B_W-1:0]    op_b,
    output logic signed [A_W+B_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

/* rtl/pfd_div10.sv */
// Serial divide-by-ten unit that retires four quotient bits per cycle.
module pfd_div10 #(
    parameter int W = 35
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic         done_reg,
    output logic [W-1:0] quotient
);

    localparam int NDIG  = (W + 3) / 4;
    localparam int PW    = NDIG * 4;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [PW-1:0]    shift_reg;
    logic [PW-1:0]    quo_reg;
    logic [3:0]       rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy;
    logic [3:0]       step_rem;
    logic [3:0]       step_q;
    logic [4:0]       step_t;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg[W-1:0];

    // Long division by ten: the partial remainder never exceeds nine, so each
    // bit needs only a five-bit compare and subtract.
    always_comb begin
        step_rem = rem_reg;
        step_q   = '0;
        step_t   = '0;
        for (int i = 0; i < 4; i++) begin
            step_t = {step_rem, shift_reg[PW-1-i]};
            if (step_t >= 5'(pfd_pkg::DERIV_DIV)) begin
                step_rem    = 4'(step_t - 5'(pfd_pkg::DERIV_DIV));
                step_q[3-i] = 1'b1;
            end else begin
                step_rem = step_t[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy && (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(NDIG);
            end else if (busy) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= PW'(dividend);
            quo_reg   <= '0;
            rem_reg   <= '0;
        end else if (busy) begin
            shift_reg <= shift_reg << 4;
            quo_reg   <= {quo_reg[PW-5:0], step_q};
            rem_reg   <= step_rem;
        end
    end

endmodule

/* rtl/pd_follow_drive_controller.sv */
// A step byte (A, B, C) runs through the ERR, MULP, MULD, DSTART, DWAIT, DEC and DUTY states
// before EMIT raises its word; any other byte goes straight from idle to EMIT.
// One word is in work at a time: s_ready is high only in the idle state, and a button word
// leaves the controller idle; a word in EMIT also waits on m_ready while the output is full.
// The divide-by-ten unit retires four bits a cycle while DWAIT waits on it; one multiplier is shared.
// Reset (aresetn low, synchronous) restores register defaults, index 1, error and phase 0.
module pd_follow_drive_controller #(
    parameter int ECHO_WIDTH       = 16,
    parameter int BEEP_HALF_PERIOD = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [7:0]                          s_rx_byte,
    input  logic [ECHO_WIDTH-1:0]               s_echo_count,
    input  logic                                s_button_next,
    input  logic                                s_button_prev,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pfd_pkg::DUTY_W-1:0]          m_forward_duty,
    output logic [pfd_pkg::DUTY_W-1:0]          m_reverse_duty,
    output logic                                m_led_one,
    output logic                                m_led_two,
    output logic                                m_buzzer
);

    localparam int EW     = ECHO_WIDTH;
    localparam int ERR_W  = EW + 2;
    localparam int DIFF_W = EW + 3;
    localparam int TERM_W = EW + 19;
    localparam int OUT_W  = TERM_W + 1;
    localparam int ABS_W  = (OUT_W > 32) ? OUT_W : 32;
    localparam int MA_W   = pfd_pkg::GAIN_W + 1;
    localparam int MB_W   = (DIFF_W > 32) ? DIFF_W : 32;
    localparam int PROD_W = MA_W + MB_W;
    localparam int BEEP_W = $clog2(2 * BEEP_HALF_PERIOD);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_MULP, ST_MULD, ST_DSTART, ST_DWAIT, ST_DEC, ST_DUTY, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [pfd_pkg::GAIN_W-1:0] kp_reg, kd_reg;
    logic [pfd_pkg::SP_W-1:0]   near_sp_reg, mid_sp_reg, far_sp_reg;

    logic [1:0]               sp_idx_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic [BEEP_W-1:0]        beep_phase_reg;

    logic [EW-1:0]              echo_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [TERM_W-1:0]   pterm_reg;
    logic                       d_neg_reg;
    logic signed [OUT_W-1:0]    o_reg;
    logic                       dir_fwd_reg, dir_rev_reg;
    logic [pfd_pkg::DUTY_W-1:0] res_fwd_reg, res_rev_reg;
    logic                       res_led1_reg, res_led2_reg, res_buz_reg;

    logic                       m_valid_reg;
    logic [pfd_pkg::DUTY_W-1:0] m_fwd_reg, m_rev_reg;
    logic                       m_led1_reg, m_led2_reg, m_buz_reg;

    logic [pfd_pkg::SP_W-1:0]       sp_sel;
    logic [1:0]                     idx_after_next, idx_after_prev;
    logic                           step_byte;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]       mul_p;
    logic signed [TERM_W-1:0]       dprod;
    logic [TERM_W-1:0]              div_in;
    logic                           div_done;
    logic [TERM_W-1:0]              div_q;
    logic signed [TERM_W-1:0]       dterm;
    logic signed [ABS_W-1:0]        o_ext;
    logic [ABS_W-1:0]               abs_o;
    logic [pfd_pkg::MAG_CLAMP_W-1:0] mag_clamp;
    logic                           above_band;
    logic [pfd_pkg::DUTY_SUM_W-1:0] duty_sum;
    logic [pfd_pkg::DUTY_W-1:0]     duty_sat;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_forward_duty = m_fwd_reg;
    assign m_reverse_duty = m_rev_reg;
    assign m_led_one      = m_led1_reg;
    assign m_led_two      = m_led2_reg;
    assign m_buzzer       = m_buz_reg;

    assign step_byte = (s_rx_byte == pfd_pkg::CHAR_A) || (s_rx_byte == pfd_pkg::CHAR_B)
                    || (s_rx_byte == pfd_pkg::CHAR_C);

    always_comb begin
        case (sp_idx_reg)
            pfd_pkg::IDX_NEAR: sp_sel = near_sp_reg;
            pfd_pkg::IDX_MID:  sp_sel = mid_sp_reg;
            default:           sp_sel = far_sp_reg;
        endcase
    end

    // The next button is applied first, then the previous button.
    always_comb begin
        idx_after_next = sp_idx_reg;
        if (s_button_next) begin
            case (sp_idx_reg)
                pfd_pkg::IDX_NEAR: idx_after_next = pfd_pkg::IDX_MID;
                pfd_pkg::IDX_MID:  idx_after_next = pfd_pkg::IDX_FAR;
                default:           idx_after_next = pfd_pkg::IDX_NEAR;
            endcase
        end
        idx_after_prev = idx_after_next;
        if (s_button_prev) begin
            case (idx_after_next)
                pfd_pkg::IDX_NEAR: idx_after_prev = pfd_pkg::IDX_FAR;
                pfd_pkg::IDX_MID:  idx_after_prev = pfd_pkg::IDX_NEAR;
                default:           idx_after_prev = pfd_pkg::IDX_MID;
            endcase
        end
    end

    assign diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    // Output magnitude and deadband test.
    assign o_ext      = ABS_W'(o_reg);
    assign abs_o      = o_ext[ABS_W-1] ? ABS_W'(-o_ext) : ABS_W'(o_ext);
    assign above_band = abs_o > ABS_W'(pfd_pkg::DEADBAND_Q16);
    assign mag_clamp  = ((abs_o >> pfd_pkg::MAG_CLAMP_W) != '0) ? '1
                      : abs_o[pfd_pkg::MAG_CLAMP_W-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_MULD: begin
                mul_a = MA_W'(kd_reg);
                mul_b = MB_W'(diff);
            end
            ST_DEC: begin
                mul_a = MA_W'(pfd_pkg::DUTY_SLOPE);
                mul_b = MB_W'(mag_clamp);
            end
            default: begin
                mul_a = MA_W'(kp_reg);
                mul_b = MB_W'(err_reg);
            end
        endcase
    end

    pfd_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_p)
    );

    assign dprod  = TERM_W'(mul_p);
    assign div_in = dprod[TERM_W-1] ? TERM_W'(-dprod) : TERM_W'(dprod);

    pfd_div10 #(
        .W (TERM_W)
    ) u_div10 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DSTART),
        .dividend (div_in),
        .done_reg (div_done),
        .quotient (div_q)
    );

    // The derivative term truncates toward zero: divide the magnitude, then restore the sign.
    assign dterm = d_neg_reg ? -$signed(div_q) : $signed(div_q);

    assign duty_sum = (dir_fwd_reg ? pfd_pkg::DUTY_SUM_W'(pfd_pkg::FWD_BASE)
                                   : pfd_pkg::DUTY_SUM_W'(pfd_pkg::REV_BASE))
                    + pfd_pkg::DUTY_SUM_W'(mul_p[pfd_pkg::SCALE_SH +: pfd_pkg::SCALED_W]);
    assign duty_sat = (duty_sum > pfd_pkg::DUTY_SUM_W'(pfd_pkg::DUTY_MAX))
                    ? pfd_pkg::DUTY_W'(pfd_pkg::DUTY_MAX) : duty_sum[pfd_pkg::DUTY_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= pfd_pkg::PROP_GAIN_RST;
            kd_reg      <= pfd_pkg::DERIV_GAIN_RST;
            near_sp_reg <= pfd_pkg::NEAR_SP_RST;
            mid_sp_reg  <= pfd_pkg::MID_SP_RST;
            far_sp_reg  <= pfd_pkg::FAR_SP_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                pfd_pkg::REG_PROP_GAIN:  kp_reg      <= cfg_wdata;
                pfd_pkg::REG_DERIV_GAIN: kd_reg      <= cfg_wdata;
                pfd_pkg::REG_NEAR_SP:    near_sp_reg <= cfg_wdata[pfd_pkg::SP_W-1:0];
                pfd_pkg::REG_MID_SP:     mid_sp_reg  <= cfg_wdata[pfd_pkg::SP_W-1:0];
                pfd_pkg::REG_FAR_SP:     far_sp_reg  <= cfg_wdata[pfd_pkg::SP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sp_idx_reg     <= pfd_pkg::IDX_MID;
            last_err_reg   <= '0;
            beep_phase_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // In the emit state the output register is reloaded rather than cleared.
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_cmd) begin
                            sp_idx_reg <= idx_after_prev;
                        end else if (step_byte) begin
                            echo_reg     <= s_echo_count;
                            res_led1_reg <= (s_rx_byte != pfd_pkg::CHAR_A);
                            res_led2_reg <= (s_rx_byte != pfd_pkg::CHAR_B);
                            state_reg    <= ST_ERR;
                        end else begin
                            res_fwd_reg  <= '0;
                            res_rev_reg  <= '0;
                            res_led1_reg <= 1'b0;
                            res_led2_reg <= 1'b0;
                            res_buz_reg  <= 1'b0;
                            state_reg    <= ST_EMIT;
                        end
                    end
                end
                ST_ERR: begin
                    err_reg   <= ERR_W'(echo_reg) - ERR_W'(sp_sel);
                    state_reg <= ST_MULP;
                end
                ST_MULP: begin
                    state_reg <= ST_MULD;
                end
                ST_MULD: begin
                    pterm_reg    <= TERM_W'(mul_p);
                    last_err_reg <= err_reg;
                    state_reg    <= ST_DSTART;
                end
                ST_DSTART: begin
                    d_neg_reg <= dprod[TERM_W-1];
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        o_reg     <= OUT_W'(pterm_reg) - OUT_W'(dterm);
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    dir_fwd_reg <= above_band && !o_ext[ABS_W-1];
                    dir_rev_reg <= above_band && o_ext[ABS_W-1];
                    if (above_band && o_ext[ABS_W-1]) begin
                        res_buz_reg <= (beep_phase_reg < BEEP_W'(BEEP_HALF_PERIOD));
                        if (beep_phase_reg == BEEP_W'(2 * BEEP_HALF_PERIOD - 1)) begin
                            beep_phase_reg <= '0;
                        end else begin
                            beep_phase_reg <= beep_phase_reg + BEEP_W'(1);
                        end
                    end else begin
                        res_buz_reg    <= 1'b0;
                        beep_phase_reg <= '0;
                    end
                    state_reg <= ST_DUTY;
                end
                ST_DUTY: begin
                    res_fwd_reg <= dir_fwd_reg ? duty_sat : '0;
                    res_rev_reg <= dir_rev_reg ? duty_sat : '0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hand the word over once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_fwd_reg   <= res_fwd_reg;
                        m_rev_reg   <= res_rev_reg;
                        m_led1_reg  <= res_led1_reg;
                        m_led2_reg  <= res_led2_reg;
                        m_buz_reg   <= res_buz_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_button_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd) |=> !$rose(m_valid))
        else $error("button word produced an output word");

    a_index_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_idx_reg != 2'd3)
        else $error("setpoint index left the legal range");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider finished outside its wait state");

    a_beep_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        beep_phase_reg <= BEEP_W'(2 * BEEP_HALF_PERIOD - 1))
        else $error("beep phase past its period");

    a_valid_rises_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_EMIT))
        else $error("output word raised outside the emit state");
`endif

endmodule
